FILE: rtl/core/i2cmts_pkg.sv
// Shared codes and the result record of the I2C master transfer sequencer.
`default_nettype none

package i2cmts_pkg;

    // Request kinds.
    localparam logic [1:0] FUNC_LOAD     = 2'd0;
    localparam logic [1:0] FUNC_START_WR = 2'd1;
    localparam logic [1:0] FUNC_START_RD = 2'd2;
    localparam logic [1:0] FUNC_STATUS   = 2'd3;

    // Bus status events.
    localparam logic [3:0] ST_START     = 4'd0;
    localparam logic [3:0] ST_RSTART    = 4'd1;
    localparam logic [3:0] ST_AW_ACK    = 4'd2;
    localparam logic [3:0] ST_AW_NACK   = 4'd3;
    localparam logic [3:0] ST_DTX_ACK   = 4'd4;
    localparam logic [3:0] ST_DTX_NACK  = 4'd5;
    localparam logic [3:0] ST_ARB_LOST  = 4'd6;
    localparam logic [3:0] ST_AR_ACK    = 4'd7;
    localparam logic [3:0] ST_AR_NACK   = 4'd8;
    localparam logic [3:0] ST_DRX_ACK   = 4'd9;
    localparam logic [3:0] ST_DRX_NACK  = 4'd10;
    localparam logic [3:0] ST_NOINFO    = 4'd11;
    localparam logic [3:0] ST_BUS_ERROR = 4'd12;

    // Bus actions.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_RX_ACK  = 3'd3;
    localparam logic [2:0] ACT_RX_NACK = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;

    // Result codes.
    localparam logic [2:0] RES_OK        = 3'd0;
    localparam logic [2:0] RES_TOO_LONG  = 3'd1;
    localparam logic [2:0] RES_ADDR_NACK = 3'd2;
    localparam logic [2:0] RES_DATA_NACK = 3'd3;
    localparam logic [2:0] RES_OTHER     = 3'd4;
    localparam logic [2:0] RES_BUSY      = 3'd5;

    // Transaction modes.
    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Direction bit appended to the device address.
    localparam logic DIR_READ  = 1'b1;
    localparam logic DIR_WRITE = 1'b0;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] out_byte;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic [2:0] result_code;
        logic [5:0] rx_count;
        logic       busy_res;
        logic       from_store;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/i2c_master_transfer_sequencer_core.sv
// I2C master transfer sequencer: top level with the result register.
// A result is registered when its request is accepted and is presented in the cycle after.
// One request per cycle is taken while the output is not stalled; the buffer's single
// access per request, with registered read data, allows this.
// Reset (synchronous, active low) clears the mode, index, limit, error and
// address registers and the result valid flag; the byte buffer is not cleared.
`default_nettype none

module i2c_master_transfer_sequencer_core import i2cmts_pkg::*; #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_func,
    input  wire logic [6:0] i_dev_address,
    input  wire logic [5:0] i_xfer_length,
    input  wire logic [4:0] i_load_index,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic [3:0] i_bus_status,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_bus_action,
    output logic [7:0]      o_out_byte,
    output logic            o_rx_valid,
    output logic [7:0]      o_rx_data,
    output logic            o_done_res,
    output logic [2:0]      o_result_code,
    output logic [5:0]      o_rx_count,
    output logic            o_busy_res
);

    localparam int IW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic          fire;
    t_result       res;
    t_result       r_res;
    logic          r_vld, n_vld;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;

    // The store is read only on an accepted request, so its data holds while stalled.
    assign o_stall = r_vld && i_stall;
    assign fire    = i_valid && !o_stall;

    i2cmts_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .IW           (IW),
        .AW           (AW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_func        (i_func),
        .i_dev_address (i_dev_address),
        .i_xfer_length (i_xfer_length),
        .i_load_index  (i_load_index),
        .i_tx_byte     (i_tx_byte),
        .i_bus_status  (i_bus_status),
        .i_rx_byte     (i_rx_byte),
        .o_res         (res),
        .o_mem_we      (mem_we),
        .o_mem_re      (mem_re),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata)
    );

    i2cmts_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we && fire),
        .i_re    (mem_re && fire),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_vld = r_vld;
        if (fire) begin
            n_vld = 1'b1;
        end else if (!i_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_valid       = r_vld;
    assign o_bus_action  = r_res.bus_action;
    assign o_out_byte    = r_res.from_store ? mem_rdata : r_res.out_byte;
    assign o_rx_valid    = r_res.rx_valid;
    assign o_rx_data     = r_res.rx_data;
    assign o_done_res    = r_res.done_res;
    assign o_result_code = r_res.result_code;
    assign o_rx_count    = r_res.rx_count;
    assign o_busy_res    = r_res.busy_res;

endmodule

`default_nettype wire

FILE: rtl/core/i2cmts_store.sv
// Byte buffer: a write enable and a read enable sharing one address, with registered read data.
`default_nettype none

module i2cmts_store #(
    parameter int BUFFER_DEPTH = 32,
    parameter int AW           = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [7:0]    i_wdata,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/i2cmts_seq.sv
// Transaction state and next-action logic; issues at most one buffer access per request.
`default_nettype none

module i2cmts_seq import i2cmts_pkg::*; #(
    parameter int BUFFER_DEPTH = 32,
    parameter int IW           = 6,
    parameter int AW           = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [1:0]    i_func,
    input  wire logic [6:0]    i_dev_address,
    input  wire logic [5:0]    i_xfer_length,
    input  wire logic [4:0]    i_load_index,
    input  wire logic [7:0]    i_tx_byte,
    input  wire logic [3:0]    i_bus_status,
    input  wire logic [7:0]    i_rx_byte,
    output t_result            o_res,
    output logic               o_mem_we,
    output logic               o_mem_re,
    output logic      [AW-1:0] o_mem_addr,
    output logic      [7:0]    o_mem_wdata
);

    // Common compare width for lengths, indexes and the depth.
    localparam int CW = (IW > 6) ? IW : 6;
    localparam logic [CW-1:0] DEPTH_W = CW'(BUFFER_DEPTH);

    logic [1:0]    r_mode,  n_mode;
    logic [IW-1:0] r_idx,   n_idx;
    logic [IW-1:0] r_limit, n_limit;
    logic [2:0]    r_err,   n_err;
    logic [7:0]    r_adrw,  n_adrw;

    logic [CW-1:0] len_w, lidx_w, idx_w, n_idx_w, limit_w;
    logic          rd, do_stop;
    t_result       res;

    assign len_w   = CW'(i_xfer_length);
    assign lidx_w  = CW'(i_load_index);
    assign idx_w   = CW'(r_idx);
    assign n_idx_w = CW'(n_idx);
    assign limit_w = CW'(r_limit);
    assign rd      = (i_func == FUNC_START_RD);

    always_comb begin
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_limit     = r_limit;
        n_err       = r_err;
        n_adrw      = r_adrw;
        res         = '0;
        do_stop     = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_addr  = idx_w[AW-1:0];
        o_mem_wdata = i_rx_byte;

        if (i_func == FUNC_LOAD) begin
            o_mem_addr  = lidx_w[AW-1:0];
            o_mem_wdata = i_tx_byte;
            o_mem_we    = (r_mode == MODE_READY) && (lidx_w < DEPTH_W);
        end else if (i_func inside {FUNC_START_WR, FUNC_START_RD}) begin
            if (len_w > DEPTH_W) begin
                res.done_res    = 1'b1;
                res.result_code = RES_TOO_LONG;
            end else if (r_mode != MODE_READY) begin
                res.done_res    = 1'b1;
                res.result_code = RES_BUSY;
            end else if (rd && (len_w == '0)) begin
                res.done_res    = 1'b1;
                res.result_code = RES_OTHER;
            end else begin
                n_mode = rd ? MODE_READ : MODE_WRITE;
                n_err  = RES_OK;
                n_idx  = '0;
                // The last read byte is taken with a NACK, so a read stops one short.
                if (rd) begin
                    n_limit = IW'(len_w - CW'(1));
                end else begin
                    n_limit = IW'(len_w);
                end
                n_adrw         = {i_dev_address, rd ? DIR_READ : DIR_WRITE};
                res.bus_action = ACT_START;
            end
        end else if (r_mode != MODE_READY) begin
            case (i_bus_status)
                ST_START, ST_RSTART: begin
                    res.bus_action = ACT_SEND;
                    res.out_byte   = r_adrw;
                end
                ST_AW_ACK, ST_DTX_ACK: begin
                    if (idx_w < limit_w) begin
                        res.bus_action = ACT_SEND;
                        res.from_store = 1'b1;
                        o_mem_re       = 1'b1;
                        n_idx          = r_idx + IW'(1);
                    end else begin
                        do_stop = 1'b1;
                    end
                end
                ST_AW_NACK, ST_AR_NACK: begin
                    n_err   = RES_ADDR_NACK;
                    do_stop = 1'b1;
                end
                ST_DTX_NACK: begin
                    n_err   = RES_DATA_NACK;
                    do_stop = 1'b1;
                end
                ST_ARB_LOST, ST_BUS_ERROR: begin
                    n_err   = RES_OTHER;
                    do_stop = 1'b1;
                end
                ST_DRX_ACK, ST_DRX_NACK: begin
                    // Bytes beyond the buffer are passed out but not kept.
                    if (idx_w < DEPTH_W) begin
                        o_mem_we = 1'b1;
                        n_idx    = r_idx + IW'(1);
                    end
                    res.rx_valid = 1'b1;
                    res.rx_data  = i_rx_byte;
                    if (i_bus_status == ST_DRX_NACK) begin
                        do_stop = 1'b1;
                    end else begin
                        res.bus_action = (n_idx_w < limit_w) ? ACT_RX_ACK : ACT_RX_NACK;
                    end
                end
                ST_AR_ACK: begin
                    res.bus_action = (idx_w < limit_w) ? ACT_RX_ACK : ACT_RX_NACK;
                end
                default: begin
                end
            endcase
            if (do_stop) begin
                res.bus_action  = ACT_STOP;
                n_mode          = MODE_READY;
                res.done_res    = 1'b1;
                res.result_code = n_err;
            end
        end

        res.rx_count = n_adrw[0] ? n_idx_w[5:0] : 6'd0;
        res.busy_res = (n_mode != MODE_READY);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_READY;
            r_idx   <= '0;
            r_limit <= '0;
            r_err   <= RES_OK;
            r_adrw  <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_limit <= n_limit;
            r_err   <= n_err;
            r_adrw  <= n_adrw;
        end
    end

endmodule

`default_nettype wire
